[design/fifo_fully_associative_tlb_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO fully associative TLB
// Short forms for clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef FIFO_FULLY_ASSOCIATIVE_TLB_MACROS_SVH
`define FIFO_FULLY_ASSOCIATIVE_TLB_MACROS_SVH

// An assertion that is checked at every rising clock edge outside reset.
`define FATLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication whose consequent must hold in the cycle after its antecedent.
`define FATLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fatlb_pkg.sv]
// ----------------------------------------------------------------------------
// FIFO fully associative TLB package
// Sizes, request codes, controller states and the records that pass along
// the row of entry cells.
// ----------------------------------------------------------------------------
package fatlb_pkg;

  localparam int unsigned TLB_ENTRIES = 16;
  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned ADDR_W = 32;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic              active;
    logic              found;
    logic [ADDR_W-1:0] vaddr;
    logic [ADDR_W-1:0] paddr;
  } token_t;

  typedef struct packed {
    logic wr_en;
    logic flush;
  } cell_ctrl_t;

endpackage

[design/fatlb_cell.sv]
// ----------------------------------------------------------------------------
// TLB entry cell
// Holds one translation and passes the lookup token on to its neighbour,
// filling in the physical address at the first matching valid entry.
// ----------------------------------------------------------------------------
module fatlb_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fatlb_pkg::cell_ctrl_t     ctrl_i,
  input  logic [fatlb_pkg::ADDR_W-1:0] wr_tag_i,
  input  logic [fatlb_pkg::ADDR_W-1:0] wr_phys_i,
  input  fatlb_pkg::token_t         token_i,
  output fatlb_pkg::token_t         token_o
);
  import fatlb_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] tag_q;
  logic [ADDR_W-1:0] phys_q;
  logic              active_q;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] vaddr_q;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  logic              match;

  assign match = token_i.active && !token_i.found && valid_q && (tag_q == token_i.vaddr);

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.flush) begin
      valid_d = 1'b0;
    end else if (ctrl_i.wr_en) begin
      valid_d = 1'b1;
    end
    found_d = token_i.found || match;
    paddr_d = match ? phys_q : token_i.paddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= token_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      tag_q  <= wr_tag_i;
      phys_q <= wr_phys_i;
    end
    found_q <= found_d;
    vaddr_q <= token_i.vaddr;
    paddr_q <= paddr_d;
  end

  assign token_o = '{active: active_q, found: found_q, vaddr: vaddr_q, paddr: paddr_q};

endmodule

[design/fifo_fully_associative_tlb.sv]
// ----------------------------------------------------------------------------
// FIFO fully associative TLB
// A lookup token walks a row of TLB_ENTRIES entry cells, one cell per cycle.
// Lookup: busy is held while the token walks the row; the result strobe is
// registered from the last cell's output, and busy falls as the strobe shows.
// Insert, flush and the unused code: result in the next cycle, one per cycle.
// Results cannot be stalled. Reset clears all valid bits, pointer and counters.
// ----------------------------------------------------------------------------
module fifo_fully_associative_tlb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [fatlb_pkg::ADDR_W-1:0] virtual_addr_i,
  input  logic [fatlb_pkg::ADDR_W-1:0] physical_addr_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [fatlb_pkg::ADDR_W-1:0] translated_addr_o,
  output logic [fatlb_pkg::ADDR_W-1:0] hit_count_o,
  output logic [fatlb_pkg::ADDR_W-1:0] miss_count_o
);
  import fatlb_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  fifo_next_q, fifo_next_d;
  logic [ADDR_W-1:0] hits_q, hits_d;
  logic [ADDR_W-1:0] misses_q, misses_d;
  logic              done_q, done_d;
  logic              hit_q, hit_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              launch;
  logic              is_lookup;
  logic              is_insert;
  logic              is_flush;
  token_t            chain [TLB_ENTRIES+1];
  token_t            tail;

  assign busy_o    = (state_q == ST_SEARCH);
  assign launch    = start_i && !busy_o;
  assign is_lookup = (req_type_i == REQ_LOOKUP);
  assign is_insert = (req_type_i == REQ_INSERT);
  assign is_flush  = (req_type_i == REQ_FLUSH);
  assign tail      = chain[TLB_ENTRIES];

  assign chain[0] = '{active: launch && is_lookup, found: 1'b0,
                      vaddr: virtual_addr_i, paddr: ALL_ONES};

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl = '{wr_en: launch && is_insert && (fifo_next_q == IDX_W'(i)),
                    flush: launch && is_flush};
    fatlb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_tag_i  (virtual_addr_i),
      .wr_phys_i (physical_addr_i),
      .token_i   (chain[i]),
      .token_o   (chain[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    fifo_next_d = fifo_next_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    hit_d       = hit_q;
    addr_d      = addr_q;
    done_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (launch) begin
          if (is_lookup) begin
            state_d = ST_SEARCH;
          end else begin
            done_d = 1'b1;
            hit_d  = 1'b0;
            addr_d = ALL_ONES;
            if (is_insert) begin
              fifo_next_d = (fifo_next_q == IDX_W'(TLB_ENTRIES - 1)) ? '0 :
                            fifo_next_q + 1'b1;
            end else if (is_flush) begin
              fifo_next_d = '0;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (tail.active) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          hit_d   = tail.found;
          addr_d  = tail.paddr;
          if (tail.found) begin
            hits_d = hits_q + 1'b1;
          end else begin
            misses_d = misses_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fifo_next_q <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      addr_q      <= ALL_ONES;
    end else begin
      state_q     <= state_d;
      fifo_next_q <= fifo_next_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      done_q      <= done_d;
      hit_q       <= hit_d;
      addr_q      <= addr_d;
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign translated_addr_o = addr_q;
  assign hit_count_o       = hits_q;
  assign miss_count_o      = misses_q;

endmodule

[design/fatlb_checker.sv]
// ----------------------------------------------------------------------------
// FIFO fully associative TLB port checker
// Watches the top-level ports for transaction ordering and counter updates.
// ----------------------------------------------------------------------------
`include "fifo_fully_associative_tlb_macros.svh"

module fatlb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   req_type_i,
  input logic [fatlb_pkg::ADDR_W-1:0] virtual_addr_i,
  input logic [fatlb_pkg::ADDR_W-1:0] physical_addr_i,
  input logic                         done_o,
  input logic                         hit_o,
  input logic [fatlb_pkg::ADDR_W-1:0] translated_addr_o,
  input logic [fatlb_pkg::ADDR_W-1:0] hit_count_o,
  input logic [fatlb_pkg::ADDR_W-1:0] miss_count_o
);
  import fatlb_pkg::*;

  logic accept_other;
  logic accept_lookup;
  logic inputs_seen;

  assign accept_lookup = start_i && !busy_o && (req_type_i == REQ_LOOKUP);
  assign accept_other  = start_i && !busy_o && (req_type_i != REQ_LOOKUP);
  assign inputs_seen   = ^{virtual_addr_i, physical_addr_i} || 1'b1;

  `FATLB_ASSERT_NEXT(a_other_done, accept_other && inputs_seen, done_o && !hit_o && translated_addr_o == ALL_ONES, "non-lookup transaction did not answer as a miss in the next cycle")
  `FATLB_ASSERT_NEXT(a_lookup_busy, accept_lookup, busy_o && !done_o, "lookup transaction did not hold busy")
  `FATLB_ASSERT(a_counts_stable, !done_o |-> ($stable(hit_count_o) && $stable(miss_count_o)), "counters changed without a result")
  `FATLB_ASSERT(a_hit_counted, (done_o && hit_o) |-> (hit_count_o != $past(hit_count_o) && $stable(miss_count_o)), "hit result did not advance the hit counter alone")

endmodule

bind fifo_fully_associative_tlb fatlb_checker u_fatlb_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the FIFO fully associative TLB
// Lookups, inserts, flushes and the unused request code are driven through the
// start/busy handshake. A shadow copy of the entries, the FIFO pointer and the
// counters predicts every reply. Each done strobe is checked against the
// oldest prediction. A directed opening is followed by random traffic in
// phases with and without idle cycles on the request side.
// ----------------------------------------------------------------------------
module testbench;
  import fatlb_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RECENT_DEPTH = 24;

  class translation_shadow;
    typedef struct {
      logic              hit;
      logic [ADDR_W-1:0] xlat;
      logic [ADDR_W-1:0] hits;
      logic [ADDR_W-1:0] misses;
    } reply_t;

    bit [TLB_ENTRIES-1:0] valid;
    logic [ADDR_W-1:0]    tag[TLB_ENTRIES];
    logic [ADDR_W-1:0]    phys[TLB_ENTRIES];
    int unsigned          fill_ptr;
    logic [ADDR_W-1:0]    hits;
    logic [ADDR_W-1:0]    misses;
    reply_t               replies_due[$];
    int unsigned          failures;

    function new();
      valid = '0;
      foreach (tag[k]) begin
        tag[k]  = '0;
        phys[k] = '0;
      end
      fill_ptr = 0;
      hits     = '0;
      misses   = '0;
      failures = 0;
    endfunction

    function void note_request(logic [1:0] kind, logic [ADDR_W-1:0] va,
                               logic [ADDR_W-1:0] pa);
      reply_t r;
      r.hit  = 1'b0;
      r.xlat = ALL_ONES;
      case (kind)
        REQ_LOOKUP: begin
          for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
            if (valid[k] && tag[k] == va) begin
              r.hit  = 1'b1;
              r.xlat = phys[k];
            end
          end
          if (r.hit) begin
            hits = hits + 1'b1;
          end else begin
            misses = misses + 1'b1;
          end
        end
        REQ_INSERT: begin
          tag[fill_ptr]   = va;
          phys[fill_ptr]  = pa;
          valid[fill_ptr] = 1'b1;
          fill_ptr = (fill_ptr == TLB_ENTRIES - 1) ? 0 : fill_ptr + 1;
        end
        REQ_FLUSH: begin
          valid    = '0;
          fill_ptr = 0;
        end
        default: begin
        end
      endcase
      r.hits   = hits;
      r.misses = misses;
      replies_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [ADDR_W-1:0] want,
                                logic [ADDR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_reply(logic hit, logic [ADDR_W-1:0] xlat,
                              logic [ADDR_W-1:0] hit_cnt, logic [ADDR_W-1:0] miss_cnt);
      reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: reply without an outstanding transaction, actual %b %h %h %h",
                 $time, hit, xlat, hit_cnt, miss_cnt);
        failures++;
        return;
      end
      r = replies_due.pop_front();
      compare_field("hit", {{(ADDR_W-1){1'b0}}, r.hit}, {{(ADDR_W-1){1'b0}}, hit});
      compare_field("translated_addr", r.xlat, xlat);
      compare_field("hit_count", r.hits, hit_cnt);
      compare_field("miss_count", r.misses, miss_cnt);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        req_type_i;
  logic [ADDR_W-1:0] virtual_addr_i;
  logic [ADDR_W-1:0] physical_addr_i;
  logic              done_o;
  logic              hit_o;
  logic [ADDR_W-1:0] translated_addr_o;
  logic [ADDR_W-1:0] hit_count_o;
  logic [ADDR_W-1:0] miss_count_o;

  translation_shadow tlb = new();
  int unsigned       idle_pct;
  logic [ADDR_W-1:0] recent_tags[$];

  fifo_fully_associative_tlb dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .req_type_i        (req_type_i),
    .virtual_addr_i    (virtual_addr_i),
    .physical_addr_i   (physical_addr_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .translated_addr_o (translated_addr_o),
    .hit_count_o       (hit_count_o),
    .miss_count_o      (miss_count_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tlb.check_reply(hit_o, translated_addr_o, hit_count_o, miss_count_o);
    end
  end

  task automatic issue(input logic [1:0] kind, input logic [ADDR_W-1:0] va,
                       input logic [ADDR_W-1:0] pa);
    int unsigned gap;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    req_type_i      <= kind;
    virtual_addr_i  <= va;
    physical_addr_i <= pa;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tlb.note_request(kind, va, pa);
    if (kind == REQ_INSERT) begin
      recent_tags.push_back(va);
      if (recent_tags.size() > RECENT_DEPTH) void'(recent_tags.pop_front());
    end
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned       idle_plan[4];
    int unsigned       pick;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;

    idle_plan       = '{0, 58, 0, 31};
    idle_pct        = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = REQ_LOOKUP;
    virtual_addr_i  = '0;
    physical_addr_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(REQ_LOOKUP, '0, '0);
    issue(REQ_INSERT, '0, ALL_ONES);
    issue(REQ_LOOKUP, '0, 32'h5A5A_5A5A);
    issue(REQ_INSERT, ALL_ONES, '0);
    issue(REQ_INSERT, '0, 32'h1234_5678);
    issue(REQ_LOOKUP, '0, ALL_ONES);
    issue(REQ_LOOKUP, ALL_ONES, '0);
    issue(REQ_UNUSED, ALL_ONES, ALL_ONES);
    issue(REQ_LOOKUP, 32'h8000_0000, '0);
    issue(REQ_FLUSH, ALL_ONES, ALL_ONES);
    issue(REQ_LOOKUP, '0, '0);
    issue(REQ_LOOKUP, ALL_ONES, '0);

    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      repeat (335) begin
        pick = $urandom_range(99);
        pa   = $urandom();
        if (pick < 48) begin
          kind = REQ_LOOKUP;
          pick = $urandom_range(99);
          if (pick < 70 && recent_tags.size() != 0) begin
            va = recent_tags[$urandom_range(recent_tags.size() - 1)];
          end else if (pick < 82 && recent_tags.size() != 0) begin
            va = recent_tags[$urandom_range(recent_tags.size() - 1)]
                 ^ (32'h1 << $urandom_range(ADDR_W - 1));
          end else if (pick < 88) begin
            va = $urandom_range(1) ? ALL_ONES : '0;
          end else begin
            va = $urandom();
          end
        end else if (pick < 92) begin
          kind = REQ_INSERT;
          pick = $urandom_range(99);
          if (pick < 25 && recent_tags.size() != 0) begin
            va = recent_tags[$urandom_range(recent_tags.size() - 1)];
          end else if (pick < 35) begin
            va = $urandom_range(7);
          end else if (pick < 40) begin
            va = $urandom_range(1) ? ALL_ONES : '0;
          end else begin
            va = $urandom();
          end
        end else if (pick < 96) begin
          kind = REQ_FLUSH;
          va   = $urandom();
        end else begin
          kind = REQ_UNUSED;
          va   = $urandom();
        end
        issue(kind, va, pa);
      end
    end

    start_i <= 1'b0;
    while (tlb.replies_due.size() != 0) @(posedge clk_i);
    repeat (TLB_ENTRIES + 4) @(posedge clk_i);

    if (tlb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
